>>> design/tcs_pkg.sv
package tcs_pkg;

	// Store geometry
	localparam int TEXEL_DEPTH = 256;
	localparam int TEX_AW      = $clog2(TEXEL_DEPTH);
	localparam int SHADE_DEPTH = 256;
	localparam int SHADE_AW    = $clog2(SHADE_DEPTH);
	localparam int PIX_W       = 8;
	localparam int TABLE_W     = 8;

	// Texture coordinate format
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = 32;
	localparam int STEP_W    = 31;
	localparam int ACC_W     = FRAC_W + 2;

	// Screen geometry
	localparam int ROW_W    = 10;
	localparam int RLEFT_W  = 11;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 9;
	localparam int ADDR_W   = 20;
	localparam int PROD_W   = ROW_W + WIDTH_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW  = 1'd1;
	localparam logic [WIDTH_W-1:0]   VIEW_WIDTH_RST  = 11'd320;
	localparam logic [ROW_W-1:0]     CENTER_ROW_RST  = 10'd100;

	// Command codes
	localparam logic [1:0] FUNC_LOAD_TEXEL = 2'd0;
	localparam logic [1:0] FUNC_LOAD_SHADE = 2'd1;
	localparam logic [1:0] FUNC_START      = 2'd2;
	localparam logic [1:0] FUNC_DRAW       = 2'd3;

	// Per-transfer control to the coordinate unit
	typedef struct packed {
		logic start;
		logic draw;
	} tcs_ctl_t;

endpackage

>>> design/tcs_ram.sv
module tcs_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tcs_coord.sv
module tcs_coord (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcs_pkg::tcs_ctl_t             ctl,
	input  logic signed [31:0]            texture_middle,
	input  logic [tcs_pkg::STEP_W-1:0]    texel_step,
	input  logic [tcs_pkg::ROW_W-1:0]     row_first,
	input  logic [tcs_pkg::ROW_W-1:0]     view_center_row,
	input  logic [tcs_pkg::HEIGHT_W-1:0]  column_height,
	output logic                          start_s1,
	output logic [tcs_pkg::TEX_AW-1:0]    tex_index
);

	import tcs_pkg::*;

	logic signed [RLEFT_W-1:0]         delta;
	logic signed [FRAC_W+RLEFT_W-1:0]  prod_full;
	logic [FRAC_W-1:0]                 prod_s1;
	logic [FRAC_W-1:0]                 mid_s1;
	logic [FRAC_W-1:0]                 frac_q;
	logic [HEIGHT_W-1:0]               height_q;
	logic signed [ACC_W-1:0]           sum;
	logic signed [ACC_W-1:0]           limit;
	logic [ACC_W-1:0]                  adv;
	logic signed [FRAC_W-1:0]          ip;
	logic [FRAC_W-1:0]                 ip_tz;
	logic                              round_up;
	logic                              pow2;
	logic [FRAC_W-1:0]                 mask;

	// Start offset: signed row distance times step, low word only
	assign delta     = $signed({1'b0, row_first}) - $signed({1'b0, view_center_row});
	assign prod_full = delta * $signed({1'b0, texel_step});

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			prod_s1 <= prod_full[FRAC_W-1:0];
			mid_s1  <= texture_middle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= ctl.start;
		end
	end

	// Advance by one step, wrap once by the column height
	assign sum   = $signed({{2{frac_q[FRAC_W-1]}}, frac_q}) + $signed(ACC_W'(texel_step));
	assign limit = $signed(ACC_W'({height_q, {FRAC_BITS{1'b0}}}));
	assign adv   = (sum >= limit) ? ACC_W'(sum - limit) : ACC_W'(sum);

	// Hold the running coordinate and the column height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q   <= '0;
			height_q <= HEIGHT_W'(1);
		end else begin
			if (ctl.start) begin
				height_q <= column_height;
			end
			if (start_s1) begin
				frac_q <= mid_s1 + prod_s1;
			end else if (ctl.draw) begin
				frac_q <= adv[FRAC_W-1:0];
			end
		end
	end

	// Integer part truncated toward zero
	assign ip       = $signed(frac_q) >>> FRAC_BITS;
	assign round_up = frac_q[FRAC_W-1] && (|frac_q[FRAC_BITS-1:0]);
	assign ip_tz    = ip + FRAC_W'(round_up);

	// Power-of-two heights mask the index
	assign pow2      = (height_q != '0) && ((height_q & (height_q - HEIGHT_W'(1))) == '0);
	assign mask      = pow2 ? FRAC_W'(height_q - HEIGHT_W'(1)) : '1;
	assign tex_index = TEX_AW'(ip_tz & mask);

endmodule

>>> design/tcs_addr.sv
module tcs_addr (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [tcs_pkg::ROW_W-1:0]     row,
	input  logic [tcs_pkg::WIDTH_W-1:0]   view_width,
	input  logic [tcs_pkg::ROW_W-1:0]     strip_x,
	output logic [tcs_pkg::ADDR_W-1:0]    pixel_address
);

	import tcs_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic [ROW_W-1:0]  x_s1;
	logic [PROD_W-1:0] sum;

	// Row times pitch, registered before the column add
	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= row * view_width;
			x_s1    <= strip_x;
		end
	end

	assign sum = prod_s1 + PROD_W'(x_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pixel_address <= sum[ADDR_W-1:0];
		end
	end

endmodule

>>> design/texture_column_sampler.sv
// Vertical texture column drawer. Load items (func 0 and 1) write one byte into the texel
// store or the colour map. A start item (func 2) latches the strip; busy is high in the
// cycle after it while the row offset product is added to the texture middle. Each draw
// item (func 3), while rows remain, puts one pixel on the result ports, marked by
// pixel_valid for exactly one cycle, after the texel store read followed by the colour
// map read. Draws may follow each other in every cycle, giving one pixel per cycle. A
// draw with no rows left gives nothing. The receiver cannot stall the output.
// Configuration writes take effect at once and belong in idle periods only.
module texture_column_sampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [7:0]                      table_index,
	input  logic [7:0]                      table_value,
	input  logic [tcs_pkg::ROW_W-1:0]       column_x,
	input  logic [tcs_pkg::ROW_W-1:0]       row_first,
	input  logic [tcs_pkg::ROW_W-1:0]       row_last,
	input  logic signed [31:0]              texture_middle,
	input  logic [tcs_pkg::STEP_W-1:0]      texel_step,
	input  logic [tcs_pkg::HEIGHT_W-1:0]    column_height,
	input  logic                            cfg_write,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            pixel_valid,
	output logic [tcs_pkg::ADDR_W-1:0]      pixel_address,
	output logic [tcs_pkg::PIX_W-1:0]       pixel_color,
	output logic                            last_pixel
);

	import tcs_pkg::*;

	logic                 fire;
	logic                 load_tex;
	logic                 load_shade;
	tcs_ctl_t             ctl;
	logic                 start_s1;
	logic [TEX_AW-1:0]    tex_index;
	logic [TABLE_W-1:0]   texel_s1;
	logic [WIDTH_W-1:0]   view_width_q;
	logic [ROW_W-1:0]     center_row_q;
	logic [ROW_W-1:0]     row_q;
	logic [RLEFT_W-1:0]   rows_left_q;
	logic [ROW_W-1:0]     strip_x_q;
	logic                 draw_s1;
	logic                 last_s1;

	// Decode the command transfer
	assign fire = start && !busy;
	assign busy = start_s1;

	always_comb begin
		load_tex   = 1'b0;
		load_shade = 1'b0;
		ctl.start  = 1'b0;
		ctl.draw   = 1'b0;
		case (func)
			FUNC_LOAD_TEXEL: load_tex   = fire;
			FUNC_LOAD_SHADE: load_shade = fire;
			FUNC_START:      ctl.start  = fire;
			FUNC_DRAW:       ctl.draw   = fire && (rows_left_q != '0);
			default:         ctl.draw   = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q <= VIEW_WIDTH_RST;
			center_row_q <= CENTER_ROW_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VIEW_WIDTH: view_width_q <= cfg_data[WIDTH_W-1:0];
				REG_CENTER_ROW: center_row_q <= cfg_data[ROW_W-1:0];
				default:        view_width_q <= view_width_q;
			endcase
		end
	end

	// Strip position and row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			rows_left_q <= '0;
			strip_x_q   <= '0;
		end else if (ctl.start) begin
			row_q       <= row_first;
			strip_x_q   <= column_x;
			rows_left_q <= (row_last >= row_first) ?
				RLEFT_W'(row_last - row_first) + RLEFT_W'(1) : '0;
		end else if (ctl.draw) begin
			row_q       <= row_q + ROW_W'(1);
			rows_left_q <= rows_left_q - RLEFT_W'(1);
		end
	end

	// Pixel pipeline valid and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_s1     <= 1'b0;
			pixel_valid <= 1'b0;
			last_s1     <= 1'b0;
			last_pixel  <= 1'b0;
		end else begin
			draw_s1     <= ctl.draw;
			pixel_valid <= draw_s1;
			last_s1     <= ctl.draw && (rows_left_q == RLEFT_W'(1));
			last_pixel  <= draw_s1 && last_s1;
		end
	end

	// Texture coordinate unit
	tcs_coord u_coord (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.texture_middle  (texture_middle),
		.texel_step      (texel_step),
		.row_first       (row_first),
		.view_center_row (center_row_q),
		.column_height   (column_height),
		.start_s1        (start_s1),
		.tex_index       (tex_index)
	);

	// Texel store: read at the draw transfer
	tcs_ram #(
		.AW (TEX_AW),
		.DW (TABLE_W)
	) u_texel_ram (
		.clk   (clk),
		.we    (load_tex),
		.waddr (TEX_AW'(table_index)),
		.wdata (table_value),
		.re    (ctl.draw),
		.raddr (tex_index),
		.rdata (texel_s1)
	);

	// Colour map: read in the following cycle with the fetched texel
	tcs_ram #(
		.AW (SHADE_AW),
		.DW (PIX_W)
	) u_shade_ram (
		.clk   (clk),
		.we    (load_shade),
		.waddr (SHADE_AW'(table_index)),
		.wdata (table_value),
		.re    (draw_s1),
		.raddr (SHADE_AW'(texel_s1)),
		.rdata (pixel_color)
	);

	// Frame buffer address
	tcs_addr u_addr (
		.clk           (clk),
		.en_s1         (ctl.draw),
		.en_s2         (draw_s1),
		.row           (row_q),
		.view_width    (view_width_q),
		.strip_x       (strip_x_q),
		.pixel_address (pixel_address)
	);

`ifndef ASSERT_OFF
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held longer than one cycle");

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_START)) |=> busy)
		else $error("start transfer did not raise busy");

	a_pixel_two_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_DRAW) && (rows_left_q != '0)) |=> ##1 pixel_valid)
		else $error("draw with rows left gave no pixel");

	a_last_with_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_pixel |-> pixel_valid) else $error("last_pixel without pixel_valid");
`endif

endmodule
